@@ design/brb_pkg.sv @@
`timescale 1ns / 1ps

package brb_pkg;

  localparam int unsigned MODE_W = 2;
  localparam int unsigned DATA_W = 8;
  localparam int unsigned CNT_W  = 10;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH    = 2'd0,
    MODE_POP     = 2'd1,
    MODE_PEEK    = 2'd2,
    MODE_DISCARD = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_OFFSET = 2'd3
  } status_e;

endpackage

@@ design/brb_if.sv @@
`timescale 1ns / 1ps

// Request channel: one operation per word.
interface brb_in_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] mode;
  logic [DATA_W-1:0] data_in;
  logic [CNT_W-1:0]  amount;

  modport source (output valid, output mode, output data_in, output amount, input ready);
  modport sink   (input valid, input mode, input data_in, input amount, output ready);
endinterface

// Response channel: one result word per request.
interface brb_out_if import brb_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        status;
  logic [DATA_W-1:0] data_out;
  logic [CNT_W-1:0]  fill_count;
  logic [CNT_W-1:0]  free_count;

  modport source (output valid, output status, output data_out, output fill_count,
                  output free_count, input ready);
  modport sink   (input valid, input status, input data_out, input fill_count,
                  input free_count, output ready);
endinterface

@@ design/brb_ram.sv @@
`timescale 1ns / 1ps

// Byte store: one write port, one read port with registered read data.
module brb_ram import brb_pkg::*; #(
  parameter  int unsigned DEPTH  = 1024,
  localparam int unsigned ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/byte_ring_buffer_peek_discard.sv @@
`timescale 1ns / 1ps

// Channel | Dir | Payload                                       | Word
// --------+-----+-----------------------------------------------+----------------------
// in_i    | in  | mode, data_in, amount                          | one operation
// out_o   | out | status, data_out, fill_count, free_count       | one result per op
//
// One operation per clock unless out_o stalls: the request is decoded against the
// pointer and fill registers, the store is written or read once, and the result lands
// in the output register in the cycle after acceptance. Throughput is one word per
// cycle unless out_o stalls, set by the single read and single write port of the byte store.
// Reset (rst_ni low, async) empties the ring: both pointers and the fill count
// go to zero; the store contents stay undefined and are never read unwritten.
// in_i.ready drops only while a result sits in the output register and out_o
// is stalled; a result taken in the same cycle frees the slot for a new word.
module byte_ring_buffer_peek_discard import brb_pkg::*; #(
  parameter int unsigned RING_SIZE = 1024
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  brb_in_if.sink    in_i,
  brb_out_if.source out_o
);

  localparam int unsigned PTR_W = $clog2(RING_SIZE);
  // compare width: wide enough for both the fill count and the 10-bit amount
  localparam int unsigned CMP_W = (PTR_W > CNT_W) ? PTR_W : CNT_W;

  // ring state
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] fill_q, fill_d;

  // result register
  logic              out_valid_q;
  status_e           status_q, status_d;
  logic              has_data_q, has_data_d;
  logic [CNT_W-1:0]  fill_cnt_q, free_cnt_q;
  logic [DATA_W-1:0] rdata;

  logic             accept;
  mode_e            mode;
  logic             empty, full;
  logic [CMP_W-1:0] fill_x, amt_x, fill_d_x, free_d_x;
  logic [PTR_W-1:0] amt_p, free_d;
  logic [PTR_W:0]   ptr_sum;
  logic [PTR_W-1:0] rd_ptr_amt, rd_ptr_inc, wr_ptr_inc;
  logic             mem_we, mem_re;
  logic [PTR_W-1:0] mem_raddr;

  // the output register frees up when its word is taken this cycle
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign mode   = mode_e'(in_i.mode);
  assign empty  = (fill_q == '0);
  assign full   = (fill_q == PTR_W'(RING_SIZE - 1));
  assign fill_x = CMP_W'(fill_q);
  assign amt_x  = CMP_W'(in_i.amount);
  assign amt_p  = amt_x[PTR_W-1:0];

  // read pointer plus offset, wrapped; only used when amount <= fill < size,
  // so the sum stays below twice the ring size
  assign ptr_sum    = {1'b0, rd_ptr_q} + {1'b0, amt_p};
  assign rd_ptr_amt = (ptr_sum >= (PTR_W+1)'(RING_SIZE))
                      ? PTR_W'(ptr_sum - (PTR_W+1)'(RING_SIZE))
                      : ptr_sum[PTR_W-1:0];
  assign rd_ptr_inc = (rd_ptr_q == PTR_W'(RING_SIZE - 1)) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_inc = (wr_ptr_q == PTR_W'(RING_SIZE - 1)) ? '0 : wr_ptr_q + 1'b1;

  always_comb begin
    rd_ptr_d   = rd_ptr_q;
    wr_ptr_d   = wr_ptr_q;
    fill_d     = fill_q;
    status_d   = ST_OK;
    has_data_d = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = rd_ptr_amt;
    unique case (mode)
      MODE_PUSH: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          mem_we   = accept;
          wr_ptr_d = wr_ptr_inc;
          fill_d   = fill_q + 1'b1;
        end
      end
      MODE_POP: begin
        mem_raddr = rd_ptr_q;
        if (empty) begin
          status_d = ST_EMPTY;
        end else begin
          mem_re     = accept;
          has_data_d = 1'b1;
          rd_ptr_d   = rd_ptr_inc;
          fill_d     = fill_q - 1'b1;
        end
      end
      MODE_PEEK: begin
        if (empty || (amt_x >= fill_x)) begin
          status_d = ST_OFFSET;
        end else begin
          mem_re     = accept;
          has_data_d = 1'b1;
        end
      end
      MODE_DISCARD: begin
        if (empty || (amt_x > fill_x)) begin
          status_d = ST_OFFSET;
        end else begin
          rd_ptr_d = rd_ptr_amt;
          fill_d   = fill_q - amt_p;
        end
      end
      default: begin
        status_d = ST_OFFSET;
      end
    endcase
  end

  // counts after the operation, reported in their low bits
  assign free_d   = PTR_W'(RING_SIZE - 1) - fill_d;
  assign fill_d_x = CMP_W'(fill_d);
  assign free_d_x = CMP_W'(free_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q    <= '0;
      wr_ptr_q    <= '0;
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        rd_ptr_q    <= rd_ptr_d;
        wr_ptr_q    <= wr_ptr_d;
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q   <= status_d;
      has_data_q <= has_data_d;
      fill_cnt_q <= fill_d_x[CNT_W-1:0];
      free_cnt_q <= free_d_x[CNT_W-1:0];
    end
  end

  brb_ram #(
    .DEPTH (RING_SIZE)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (in_i.data_in),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  assign out_o.valid      = out_valid_q;
  assign out_o.status     = status_q;
  assign out_o.data_out   = has_data_q ? rdata : '0;
  assign out_o.fill_count = fill_cnt_q;
  assign out_o.free_count = free_cnt_q;

  // fill register tracks the pointer distance
  a_fill_matches_ptrs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((wr_ptr_q >= rd_ptr_q) && (fill_q == wr_ptr_q - rd_ptr_q)) ||
    ((wr_ptr_q <  rd_ptr_q) &&
     ((PTR_W+1)'(fill_q) == (PTR_W+1)'(wr_ptr_q) + (PTR_W+1)'(RING_SIZE)
                            - (PTR_W+1)'(rd_ptr_q))))
    else $error("fill count out of step with pointers");

  // an accepted word always produces a result next cycle
  a_accept_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted word produced no result");

  // failed operations never return data
  a_no_data_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (status_q != ST_OK)) |-> !has_data_q)
    else $error("data flagged on failed operation");

  // a failed operation leaves the ring untouched
  a_error_no_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (status_d != ST_OK)) |=> ($stable(rd_ptr_q) && $stable(wr_ptr_q)))
    else $error("pointers moved on failed operation");

endmodule
